// ===== src/bple_pkg.sv =====
// ----------------------------------------------------------------------------
// bple_pkg
// Shared constants and types for the button press / long-press event block.
// ----------------------------------------------------------------------------
package bple_pkg;

  // Field widths
  localparam int LEVEL_W  = 5;
  localparam int NOW_W    = 32;
  localparam int DELAY_W  = 16;
  localparam int INDEX_W  = 3;

  // Default switch count and delay after reset (milliseconds)
  localparam int                 NUM_SWITCHES_DEF = 5;
  localparam logic [DELAY_W-1:0] DELAY_RESET      = 16'd1000;

  // Event queue between classifier and emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== src/button_press_long_press_events.sv =====
// ----------------------------------------------------------------------------
// button_press_long_press_events
// Press and long-press event detector for a bank of polled switches.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  in_     | input     | in_valid / in_stall  | switch_levels, now_ms
//  out_    | output    | out_valid / out_stall| switch_index, is_long, last
//  cfg_    | input     | cfg_wr_en            | cfg_wr_data (long-press delay)
//
//  A poll is classified in the cycle it is accepted; a poll may be accepted
//  every cycle while the two-entry event queue has room.
//  The emitter sends one item per cycle unless out_stall holds it, so a
//  poll with k events gives k items (at most NUM_SWITCHES); a poll with no
//  events pushes nothing. Items go from the queue through the record
//  registers to the output register. Reset is synchronous; no clearing pass.
//  out_stall holds the output register; in_stall rises only when the queue
//  is full.
// ----------------------------------------------------------------------------
module button_press_long_press_events #(
  parameter int NUM_SWITCHES = bple_pkg::NUM_SWITCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bple_pkg::LEVEL_W-1:0]  in_switch_levels,
  input  logic [bple_pkg::NOW_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bple_pkg::INDEX_W-1:0]  out_switch_index,
  output logic                          out_is_long,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [bple_pkg::DELAY_W-1:0]  cfg_wr_data
);
  import bple_pkg::*;

  logic [DELAY_W-1:0]        delay_r, delay_nxt;
  logic                      push;
  logic [2*NUM_SWITCHES-1:0] push_data;
  logic                      pop;
  logic [2*NUM_SWITCHES-1:0] pop_data;
  q_status_t                 q_status;

  // Long-press delay register
  always_comb begin
    delay_nxt = delay_r;
    if (cfg_wr_en) begin
      delay_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  bple_front #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_switch_levels (in_switch_levels),
    .in_now_ms        (in_now_ms),
    .delay_i          (delay_r),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  bple_queue #(
    .DATA_W (2 * NUM_SWITCHES)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  bple_back #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status_i       (q_status),
    .q_data_i         (pop_data),
    .pop_o            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_switch_index (out_switch_index),
    .out_is_long      (out_is_long),
    .out_last         (out_last)
  );

endmodule

// ===== src/bple_front.sv =====
// ----------------------------------------------------------------------------
// bple_front
// Poll classifier: tracks levels, press stamps and armed flags, and pushes
// the press and long-press masks of each poll that has events.
// ----------------------------------------------------------------------------
module bple_front #(
  parameter int NUM_SWITCHES = bple_pkg::NUM_SWITCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bple_pkg::LEVEL_W-1:0]  in_switch_levels,
  input  logic [bple_pkg::NOW_W-1:0]    in_now_ms,
  input  logic [bple_pkg::DELAY_W-1:0]  delay_i,
  input  bple_pkg::q_status_t           q_status_i,
  output logic                          push_o,
  output logic [2*NUM_SWITCHES-1:0]     push_data_o
);
  import bple_pkg::*;

  logic [NUM_SWITCHES-1:0] prev_levels_r, prev_levels_nxt;
  logic [NUM_SWITCHES-1:0] armed_r, armed_nxt;
  logic [NOW_W-1:0]        stamp_r [NUM_SWITCHES];

  logic [LEVEL_W+NUM_SWITCHES-1:0] levels_ext;
  logic [NUM_SWITCHES-1:0]         levels;
  logic [NUM_SWITCHES-1:0]         rising;
  logic [NUM_SWITCHES-1:0]         falling;
  logic [NUM_SWITCHES-1:0]         due;
  logic [NUM_SWITCHES-1:0]         long_ev;
  logic                            accept;

  // Mask level bits to the switches that exist
  assign levels_ext = {{NUM_SWITCHES{1'b0}}, in_switch_levels};
  assign levels     = levels_ext[NUM_SWITCHES-1:0];
  assign rising     = levels & ~prev_levels_r;
  assign falling    = prev_levels_r & ~levels;

  // Elapsed time per switch, wrap-safe
  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      due[i] = (in_now_ms - stamp_r[i]) > {{(NOW_W-DELAY_W){1'b0}}, delay_i};
    end
  end

  // A switch pressed in this poll is not yet armed, so never long
  assign long_ev = armed_r & ~falling & due;

  assign in_stall    = q_status_i.full;
  assign accept      = in_valid & ~q_status_i.full;
  assign push_o      = accept & ((|rising) | (|long_ev));
  assign push_data_o = {long_ev, rising};

  // Next state on accept
  always_comb begin
    prev_levels_nxt = prev_levels_r;
    armed_nxt       = armed_r;
    if (accept) begin
      prev_levels_nxt = levels;
      armed_nxt       = (armed_r & ~falling & ~long_ev) | rising;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
      armed_r       <= '0;
    end else begin
      prev_levels_r <= prev_levels_nxt;
      armed_r       <= armed_nxt;
    end
  end

  // Record press time
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (accept && rising[i]) begin
        stamp_r[i] <= in_now_ms;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |-> !q_status_i.full)
    else $error("push into full queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |-> (push_data_o != '0))
    else $error("pushed record without events");

  a_armed_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (armed_r & ~prev_levels_r) == '0)
    else $error("armed switch not held");

endmodule

// ===== src/bple_queue.sv =====
// ----------------------------------------------------------------------------
// bple_queue
// Short FIFO of per-poll event records between classifier and emitter.
// ----------------------------------------------------------------------------
module bple_queue #(
  parameter int DATA_W = 2 * bple_pkg::NUM_SWITCHES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  logic [DATA_W-1:0]    push_data_i,
  input  logic                 pop_i,
  output logic [DATA_W-1:0]    pop_data_o,
  output bple_pkg::q_status_t  status_o
);
  import bple_pkg::*;

  logic [DATA_W-1:0]      mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign status_o.empty = (count_r == '0);
  assign status_o.full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_data_o     = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_i && pop_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store record
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !status_o.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !status_o.empty)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== src/bple_back.sv =====
// ----------------------------------------------------------------------------
// bple_back
// Event emitter: walks one record's press then long-press mask in ascending
// switch order to an output register, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module bple_back #(
  parameter int NUM_SWITCHES = bple_pkg::NUM_SWITCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bple_pkg::q_status_t           q_status_i,
  input  logic [2*NUM_SWITCHES-1:0]     q_data_i,
  output logic                          pop_o,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bple_pkg::INDEX_W-1:0]  out_switch_index,
  output logic                          out_is_long,
  output logic                          out_last
);
  import bple_pkg::*;

  logic [NUM_SWITCHES-1:0] press_r, press_nxt;
  logic [NUM_SWITCHES-1:0] long_r, long_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]      out_index_r;
  logic                    out_is_long_r;
  logic                    out_last_r;

  logic                    have_work;
  logic                    use_press;
  logic [NUM_SWITCHES-1:0] sel;
  logic [NUM_SWITCHES-1:0] sel_low;
  logic [NUM_SWITCHES-1:0] press_rem;
  logic [NUM_SWITCHES-1:0] long_rem;
  logic [INDEX_W-1:0]      sel_index;
  logic                    is_last;
  logic                    out_load;
  logic                    emit;

  assign have_work = (|press_r) | (|long_r);
  assign use_press = |press_r;
  assign sel       = use_press ? press_r : long_r;
  assign sel_low   = sel & (~sel + NUM_SWITCHES'(1));
  assign press_rem = use_press ? (press_r & ~sel_low) : press_r;
  assign long_rem  = use_press ? long_r : (long_r & ~sel_low);
  assign is_last   = (press_rem == '0) && (long_rem == '0);

  // Index of the lowest pending switch
  always_comb begin
    sel_index = '0;
    for (int i = NUM_SWITCHES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        sel_index = INDEX_W'(i);
      end
    end
  end

  assign out_load = ~out_valid_r | ~out_stall;
  assign emit     = have_work & out_load;
  assign pop_o    = ~q_status_i.empty & (~have_work | (emit & is_last));

  // Load next record or drop the emitted bit
  always_comb begin
    press_nxt     = press_r;
    long_nxt      = long_r;
    out_valid_nxt = out_valid_r;
    if (pop_o) begin
      press_nxt = q_data_i[NUM_SWITCHES-1:0];
      long_nxt  = q_data_i[2*NUM_SWITCHES-1:NUM_SWITCHES];
    end else if (emit) begin
      press_nxt = press_rem;
      long_nxt  = long_rem;
    end
    if (out_load) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r     <= '0;
      long_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      press_r     <= press_nxt;
      long_r      <= long_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold item payload until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_index_r   <= sel_index;
      out_is_long_r <= ~use_press;
      out_last_r    <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_switch_index = out_index_r;
  assign out_is_long      = out_is_long_r;
  assign out_last         = out_last_r;

  a_one_event_per_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (press_r & long_r) == '0)
    else $error("switch has both press and long-press pending");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> !q_status_i.empty)
    else $error("pop from empty queue");

  a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_o && have_work) |-> (emit && is_last))
    else $error("record replaced before its last item");

endmodule
